// ===== hdl/tcara_pkg.sv =====
// Package for the two-class alternating resource arbiter.
// Holds field widths, mode and status codes, and the controller/datapath structs.
// No dependencies.
package tcara_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned STATUS_W        = 2;

  // Transaction mode
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REL_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the incoming transaction
    logic exec;        // evaluate and commit the transaction
    logic finish_pop;  // queue read data is valid, deliver the grant
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_pop;    // release hands off to a queued requester
  } dp_status_t;

endpackage

// ===== hdl/tcara_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcara_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tcara_ctrl.sv =====
// Sequencing state machine for the arbiter: idle, execute, queue read.
// Depends on tcara_pkg for the command and status structs.
module tcara_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tcara_pkg::dp_status_t status_i,
  output logic                  busy_o,
  output tcara_pkg::ctrl_cmd_t  cmd_o
);
  import tcara_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = status_i.need_pop ? S_POP : S_IDLE;
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  assign busy_o           = (state_q != S_IDLE);
  assign cmd_o.capture    = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec       = (state_q == S_EXEC);
  assign cmd_o.finish_pop = (state_q == S_POP);

`ifndef NO_ASSERTIONS
  // A queue read cycle only follows an execute cycle
  a_pop_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> ($past(state_q) == S_EXEC))
    else $error("queue read state not entered from execute");

  // An accepted transaction is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed");

  // Execute without a queue read returns to idle
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && !status_i.need_pop) |=> (state_q == S_IDLE))
    else $error("execute without queue read did not return to idle");
`endif

endmodule

// ===== hdl/tcara_dp.sv =====
// Datapath of the arbiter: holder state, per-class queue pointers, shared queue RAM,
// result registers. Depends on tcara_pkg and tcara_ram.
module tcara_dp #(
  parameter int unsigned QUEUE_DEPTH = tcara_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tcara_pkg::ctrl_cmd_t           cmd_i,
  output tcara_pkg::dp_status_t          status_o,
  input  logic                           mode_i,
  input  logic                           category_i,
  input  logic [tcara_pkg::ID_W-1:0]     requester_id_i,
  output logic                           done_o,
  output logic                           grant_valid_o,
  output logic [tcara_pkg::ID_W-1:0]     granted_id_o,
  output logic                           granted_category_o,
  output logic                           queued_o,
  output logic [tcara_pkg::STATUS_W-1:0] status_o_field,
  output logic                           resource_busy_o
);
  import tcara_pkg::*;

  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = PW + 1;
  localparam int unsigned RAM_DEPTH = 2 * (2 ** PW);
  localparam int unsigned RAM_AW    = PW + 1;
  localparam logic [CW-1:0] QD      = CW'(QUEUE_DEPTH);

  // Captured transaction
  logic              mode_q, cat_q;
  logic [ID_W-1:0]   id_q;

  // Arbiter state
  logic              holder_valid_q, holder_valid_d;
  logic              holder_class_q, holder_class_d;
  logic [PW-1:0]     head0_q, head0_d, head1_q, head1_d;
  logic [CW-1:0]     cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic              pop_cls_q, pop_cls_d;

  // Result registers
  logic              done_q, done_d;
  logic              res_gv_q, res_gv_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic              res_cat_q, res_cat_d;
  logic              res_queued_q, res_queued_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic              res_busy_q, res_busy_d;

  // Queue RAM port signals
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [ID_W-1:0]   ram_rdata;

  // Pointer arithmetic
  logic [PW-1:0]     head_req, head_pop, head_pop_next;
  logic [CW-1:0]     cnt_req, cnt_oth, cnt_own;
  logic [CW-1:0]     tail_sum, head_inc;
  logic [PW-1:0]     tail;
  logic              other_cls, pop_cls, pop_any;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      cat_q  <= category_i;
      id_q   <= requester_id_i;
    end
  end

  // Request side: tail slot of the requester's class
  assign head_req  = cat_q ? head1_q : head0_q;
  assign cnt_req   = cat_q ? cnt1_q : cnt0_q;
  assign tail_sum  = {1'b0, head_req} + cnt_req;
  assign tail      = (tail_sum >= QD) ? PW'(tail_sum - QD) : tail_sum[PW-1:0];

  // Release side: other class first, then the holder's own class
  assign other_cls     = ~holder_class_q;
  assign cnt_oth       = other_cls ? cnt1_q : cnt0_q;
  assign cnt_own       = holder_class_q ? cnt1_q : cnt0_q;
  assign pop_any       = (cnt_oth != '0) || (cnt_own != '0);
  assign pop_cls       = (cnt_oth != '0) ? other_cls : holder_class_q;
  assign head_pop      = pop_cls ? head1_q : head0_q;
  assign head_inc      = {1'b0, head_pop} + CW'(1);
  assign head_pop_next = (head_inc >= QD) ? '0 : head_inc[PW-1:0];

  assign status_o.need_pop = (mode_q == MODE_RELEASE) && holder_valid_q && pop_any;

  // Transaction evaluation and commit
  always_comb begin
    holder_valid_d = holder_valid_q;
    holder_class_d = holder_class_q;
    head0_d        = head0_q;
    head1_d        = head1_q;
    cnt0_d         = cnt0_q;
    cnt1_d         = cnt1_q;
    pop_cls_d      = pop_cls_q;
    done_d         = 1'b0;
    res_gv_d       = res_gv_q;
    res_id_d       = res_id_q;
    res_cat_d      = res_cat_q;
    res_queued_d   = res_queued_q;
    res_status_d   = res_status_q;
    res_busy_d     = res_busy_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = {cat_q, tail};
    ram_raddr      = {pop_cls, head_pop};

    if (cmd_i.exec) begin
      res_gv_d     = 1'b0;
      res_id_d     = '0;
      res_cat_d    = 1'b0;
      res_queued_d = 1'b0;
      res_status_d = STATUS_OK;
      if (mode_q == MODE_REQUEST) begin
        done_d = 1'b1;
        if (!holder_valid_q) begin
          holder_valid_d = 1'b1;
          holder_class_d = cat_q;
          res_gv_d       = 1'b1;
          res_id_d       = id_q;
          res_cat_d      = cat_q;
        end else if (cnt_req < QD) begin
          ram_we       = 1'b1;
          res_queued_d = 1'b1;
          if (cat_q) cnt1_d = cnt1_q + CW'(1);
          else       cnt0_d = cnt0_q + CW'(1);
        end else begin
          res_status_d = STATUS_FULL;
        end
        res_busy_d = 1'b1;
      end else if (!holder_valid_q) begin
        done_d       = 1'b1;
        res_status_d = STATUS_REL_FREE;
        res_busy_d   = 1'b0;
      end else if (pop_any) begin
        // Grant is delivered after the queue read returns
        ram_re         = 1'b1;
        pop_cls_d      = pop_cls;
        holder_class_d = pop_cls;
        if (pop_cls) begin
          head1_d = head_pop_next;
          cnt1_d  = cnt1_q - CW'(1);
        end else begin
          head0_d = head_pop_next;
          cnt0_d  = cnt0_q - CW'(1);
        end
      end else begin
        done_d         = 1'b1;
        holder_valid_d = 1'b0;
        res_busy_d     = 1'b0;
      end
    end else if (cmd_i.finish_pop) begin
      done_d       = 1'b1;
      res_gv_d     = 1'b1;
      res_id_d     = ram_rdata;
      res_cat_d    = pop_cls_q;
      res_busy_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holder_valid_q <= 1'b0;
      holder_class_q <= 1'b0;
      head0_q        <= '0;
      head1_q        <= '0;
      cnt0_q         <= '0;
      cnt1_q         <= '0;
      pop_cls_q      <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      holder_valid_q <= holder_valid_d;
      holder_class_q <= holder_class_d;
      head0_q        <= head0_d;
      head1_q        <= head1_d;
      cnt0_q         <= cnt0_d;
      cnt1_q         <= cnt1_d;
      pop_cls_q      <= pop_cls_d;
      done_q         <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_gv_q     <= res_gv_d;
    res_id_q     <= res_id_d;
    res_cat_q    <= res_cat_d;
    res_queued_q <= res_queued_d;
    res_status_q <= res_status_d;
    res_busy_q   <= res_busy_d;
  end

  // Both class queues share one RAM, class bit on top of the address
  tcara_ram #(
    .WIDTH (ID_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (id_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o             = done_q;
  assign grant_valid_o      = res_gv_q;
  assign granted_id_o       = res_id_q;
  assign granted_category_o = res_cat_q;
  assign queued_o           = res_queued_q;
  assign status_o_field     = res_status_q;
  assign resource_busy_o    = res_busy_q;

`ifndef NO_ASSERTIONS
  // Queue fill never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt0_q <= QD) && (cnt1_q <= QD))
    else $error("class queue count exceeds depth");

  // A delivered grant leaves the resource held
  a_grant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_gv_q) |-> (res_busy_q && holder_valid_q))
    else $error("grant delivered while resource free");

  // Waiters only exist while someone holds the resource
  a_wait_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt0_q != '0) || (cnt1_q != '0)) |-> holder_valid_q)
    else $error("queued requesters while resource free");
`endif

endmodule

// ===== hdl/two_class_alternating_resource_arbiter_top.sv =====
// Sequence: a request or a release with no waiter is captured, then executed, and its
// result strobe is registered from the execute state; a release that hands off to a
// waiter adds a queue read state, set by the registered read of the shared queue RAM.
// The next transaction may start in the cycle the result is shown.
// Reset (rst_ni low, asynchronous) frees the resource and empties both class queues.
// The receiver cannot stall: each result is valid for the single done_o cycle.
module two_class_alternating_resource_arbiter_top #(
  parameter int unsigned QUEUE_DEPTH = tcara_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           mode_i,
  input  logic                           category_i,
  input  logic [tcara_pkg::ID_W-1:0]     requester_id_i,
  output logic                           done_o,
  output logic                           grant_valid_o,
  output logic [tcara_pkg::ID_W-1:0]     granted_id_o,
  output logic                           granted_category_o,
  output logic                           queued_o,
  output logic [tcara_pkg::STATUS_W-1:0] status_o,
  output logic                           resource_busy_o
);
  import tcara_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Sequencer
  tcara_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  // Arbiter state and queues
  tcara_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (dp_status),
    .mode_i             (mode_i),
    .category_i         (category_i),
    .requester_id_i     (requester_id_i),
    .done_o             (done_o),
    .grant_valid_o      (grant_valid_o),
    .granted_id_o       (granted_id_o),
    .granted_category_o (granted_category_o),
    .queued_o           (queued_o),
    .status_o_field     (status_o),
    .resource_busy_o    (resource_busy_o)
  );

endmodule

// ===== tb/tb_two_class_alternating_resource_arbiter_top.sv =====
// Self-checking testbench for the two-class alternating resource arbiter.
// Drives request and release transactions and checks every result against a scoreboard.
// Depends on tcara_pkg and two_class_alternating_resource_arbiter_top.
module tb_two_class_alternating_resource_arbiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcara_pkg::*;

  localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1420;
  localparam int unsigned PHASES       = 4;

  // One result transaction as seen on the output ports
  typedef struct packed {
    logic                grant_valid;
    logic [ID_W-1:0]     granted_id;
    logic                granted_category;
    logic                queued;
    logic [STATUS_W-1:0] status;
    logic                resource_busy;
  } arb_result_t;

  // Tracks holder and waiter queues, predicts each result and checks it
  class grant_scoreboard;
    bit              holder_valid;
    bit              holder_class;
    logic [ID_W-1:0] waiters [2][DEPTH];
    int unsigned     wait_head [2];
    int unsigned     wait_count [2];
    arb_result_t     expected_results [$];
    int unsigned     mismatches;

    function new();
      holder_valid  = 1'b0;
      holder_class  = 1'b0;
      wait_head     = '{0, 0};
      wait_count    = '{0, 0};
      mismatches    = 0;
    endfunction

    // Apply one accepted transaction to the predicted state
    function void note_transaction(logic mode, logic cat, logic [ID_W-1:0] id);
      arb_result_t r;
      bit          next_cls;
      r = '0;
      r.status = STATUS_OK;
      if (mode == MODE_REQUEST) begin
        if (!holder_valid) begin
          holder_valid       = 1'b1;
          holder_class       = cat;
          r.grant_valid      = 1'b1;
          r.granted_id       = id;
          r.granted_category = cat;
        end else if (wait_count[cat] < DEPTH) begin
          waiters[cat][(wait_head[cat] + wait_count[cat]) % DEPTH] = id;
          wait_count[cat]++;
          r.queued = 1'b1;
        end else begin
          r.status = STATUS_FULL;
        end
      end else if (!holder_valid) begin
        r.status = STATUS_REL_FREE;
      end else begin
        // other class first, then the holder's own class
        next_cls = ~holder_class;
        if (wait_count[next_cls] == 0) next_cls = holder_class;
        if (wait_count[next_cls] != 0) begin
          r.grant_valid       = 1'b1;
          r.granted_id        = waiters[next_cls][wait_head[next_cls]];
          r.granted_category  = next_cls;
          wait_head[next_cls] = (wait_head[next_cls] + 1) % DEPTH;
          wait_count[next_cls]--;
          holder_class        = next_cls;
        end else begin
          holder_valid = 1'b0;
        end
      end
      r.resource_busy = holder_valid;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result with the oldest prediction
    task check_result(arb_result_t got);
      arb_result_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing pending: %p", got));
        return;
      end
      exp = expected_results.pop_front();
      if (got.grant_valid !== exp.grant_valid)
        report($sformatf("grant_valid %b, want %b", got.grant_valid, exp.grant_valid));
      if (got.granted_id !== exp.granted_id)
        report($sformatf("granted_id %h, want %h", got.granted_id, exp.granted_id));
      if (got.granted_category !== exp.granted_category)
        report($sformatf("granted_category %b, want %b",
                         got.granted_category, exp.granted_category));
      if (got.queued !== exp.queued)
        report($sformatf("queued %b, want %b", got.queued, exp.queued));
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.resource_busy !== exp.resource_busy)
        report($sformatf("resource_busy %b, want %b", got.resource_busy, exp.resource_busy));
    endtask

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                mode_i;
  logic                category_i;
  logic [ID_W-1:0]     requester_id_i;
  logic                done_o;
  logic                grant_valid_o;
  logic [ID_W-1:0]     granted_id_o;
  logic                granted_category_o;
  logic                queued_o;
  logic [STATUS_W-1:0] status_o;
  logic                resource_busy_o;

  grant_scoreboard sb = new();

  two_class_alternating_resource_arbiter_top #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .mode_i             (mode_i),
    .category_i         (category_i),
    .requester_id_i     (requester_id_i),
    .done_o             (done_o),
    .grant_valid_o      (grant_valid_o),
    .granted_id_o       (granted_id_o),
    .granted_category_o (granted_category_o),
    .queued_o           (queued_o),
    .status_o           (status_o),
    .resource_busy_o    (resource_busy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result monitor: outputs sampled at the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      sb.check_result('{grant_valid_o, granted_id_o, granted_category_o,
                        queued_o, status_o, resource_busy_o});
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(logic mode, logic cat, logic [ID_W-1:0] id);
    start_i        <= 1'b1;
    mode_i         <= mode;
    category_i     <= cat;
    requester_id_i <= id;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_transaction(mode, cat, id);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending until every pending result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic random_item(int unsigned req_pct);
    logic mode;
    mode = ($urandom_range(99) < req_pct) ? MODE_REQUEST : MODE_RELEASE;
    send_item(mode, 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned phase_idle [PHASES];
    int unsigned req_mix [4];
    int unsigned req_pct;
    int unsigned ph;
    int unsigned n;

    phase_idle     = '{0, 45, 0, 25};
    req_mix        = '{20, 50, 75, 95};
    req_pct        = 50;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    mode_i         = MODE_REQUEST;
    category_i     = 1'b0;
    requester_id_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: release while free, hand-off order, going free, full queue
    send_item(MODE_RELEASE, 1'b0, 8'h00);
    send_item(MODE_REQUEST, 1'b0, 8'h00);
    send_item(MODE_REQUEST, 1'b1, 8'hFF);
    send_item(MODE_REQUEST, 1'b0, 8'h00);   // holder asks again, gets queued
    send_item(MODE_RELEASE, 1'b0, 8'h00);   // other class wins
    send_item(MODE_RELEASE, 1'b1, 8'hFF);   // back to class 0
    send_item(MODE_RELEASE, 1'b0, 8'h00);   // nobody waiting, goes free
    send_item(MODE_RELEASE, 1'b1, 8'hFF);   // free again, fields ignored
    send_item(MODE_REQUEST, 1'b1, 8'h5A);
    send_item(MODE_REQUEST, 1'b1, 8'hA5);
    send_item(MODE_RELEASE, 1'b0, 8'h3C);   // other empty, own class served
    for (n = 0; n < DEPTH; n++) send_item(MODE_REQUEST, 1'b1, 8'(n * 17));
    send_item(MODE_REQUEST, 1'b1, 8'hC3);   // class 1 queue full, dropped
    drain_results();

    // Random phases with shifting request/release mix
    for (ph = 0; ph < PHASES; ph++) begin
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) req_pct = req_mix[$urandom_range(3)];
        if (phase_idle[ph] != 0 && $urandom_range(99) < phase_idle[ph])
          pause_sender($urandom_range(1, 4));
        random_item(req_pct);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tcara_pkg.sv
hdl/tcara_ram.sv
hdl/tcara_ctrl.sv
hdl/tcara_dp.sv
hdl/two_class_alternating_resource_arbiter_top.sv
tb/tb_two_class_alternating_resource_arbiter_top.sv
